/* hw/rtl/nfsa_pkg.sv */
// Shared types and constants of the next-fit slot allocator.
`default_nettype none
package nfsa_pkg;

  localparam int WORD_W = 32;  // bits of busy map per memory word
  localparam int BIT_W  = 5;   // bit select inside one word

  typedef logic [WORD_W-1:0] map_word_t;
  typedef logic [BIT_W-1:0]  bit_sel_t;

  localparam logic ACT_ALLOC   = 1'b0;
  localparam logic ACT_RELEASE = 1'b1;

  typedef enum logic [1:0] {
    ERR_OK        = 2'd0,
    ERR_POOL_FULL = 2'd1,
    ERR_NOT_BUSY  = 2'd2
  } err_code_t;

  // Which parts of a word the find-first-free unit must ignore this visit.
  typedef struct packed {
    logic     first_visit;  // ignore bits below start_bit
    logic     last_visit;   // ignore bits at or above start_bit
    logic     tail_word;    // ignore bits past the end of the pool
    bit_sel_t start_bit;
  } scan_ctl_t;

endpackage
`default_nettype wire

/* hw/rtl/next_fit_slot_allocator.sv */
// Top level of the next-fit slot allocator: handshake, sequencer and state.
`default_nettype none
// Next-fit allocator over a pool of SLOTS slots. Each input word either
// allocates (in_tuser = 0) or releases the slot in in_tdata (in_tuser = 1),
// and gives exactly one result word. The busy map lives in a memory of
// 32-bit rows that is read one row per cycle and checked by a single
// find-first-free unit. An allocate visits k rows from the search pointer
// (1 up to ceil(SLOTS/32) + 1, the start row being visited twice on a full
// wrap), so 1 to 9 rows at 256 slots. A release reads the row of its slot,
// except one with an out-of-range slot, which skips the map read. The
// block takes one request at a time; a finished result may wait in the
// output register while the next request is accepted.
module next_fit_slot_allocator #(
  parameter int SLOTS = 256
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] slot
  input  wire logic [0:0]  in_tuser,   // [0] action
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // [7:0] slot_index, [16:8] live_count
  output logic [2:0]       out_tuser   // [0] granted, [2:1] error_code
);
  import nfsa_pkg::*;

  localparam int WORDS     = (SLOTS + WORD_W - 1) / WORD_W;
  localparam int WW        = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int IXW       = WW + BIT_W;
  localparam int SXW       = (IXW > 8) ? IXW : 8;
  localparam int VW        = $clog2(WORDS + 1);
  localparam int CNT_W     = $clog2(SLOTS + 1);
  localparam int CXW       = (CNT_W > 9) ? CNT_W : 9;
  localparam int TAIL_BITS = SLOTS - (WORDS - 1) * WORD_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_REL,
    ST_DONE
  } state_t;

  state_t          state_r;
  logic [IXW-1:0]  search_r, search_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [WW-1:0]   word_r, word_nxt;
  logic [VW-1:0]   visit_r, visit_nxt;
  bit_sel_t        rel_bit_r, rel_bit_nxt;
  logic [7:0]      rel_slot_r, rel_slot_nxt;

  logic            res_grant_r, res_grant_nxt;
  logic [7:0]      res_slot_r, res_slot_nxt;
  err_code_t       res_err_r, res_err_nxt;
  state_t          state_nxt;

  logic            out_vld_r, out_vld_nxt;
  logic            out_grant_r, out_grant_nxt;
  logic [7:0]      out_slot_r, out_slot_nxt;
  err_code_t       out_err_r, out_err_nxt;
  logic [8:0]      out_live_r, out_live_nxt;

  logic            rd_en, wr_en;
  logic [WW-1:0]   rd_addr, wr_addr;
  map_word_t       rd_data, wr_data;

  scan_ctl_t       ctl;
  logic            ffz_found;
  bit_sel_t        ffz_bit;

  logic            in_acc;
  logic [WW-1:0]   start_word, word_inc;
  logic [SXW-1:0]  slot_wide, alloc_wide;
  logic [IXW-1:0]  alloc_idx;
  logic            slot_in_pool;
  logic [CXW-1:0]  count_wide;

  nfsa_map #(.WORDS(WORDS), .WW(WW)) u_map (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  nfsa_ffz #(.TAIL_BITS(TAIL_BITS)) u_ffz (
    .word      (rd_data),
    .ctl       (ctl),
    .found     (ffz_found),
    .first_bit (ffz_bit)
  );

  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign start_word = search_r[IXW-1:BIT_W];
  assign word_inc   = (word_r == WW'(WORDS - 1)) ? '0 : word_r + 1'b1;
  assign slot_wide  = SXW'(in_tdata);
  assign slot_in_pool = (32'(in_tdata) < 32'(SLOTS));
  assign alloc_idx  = {word_r, ffz_bit};
  assign alloc_wide = SXW'(alloc_idx);

  assign ctl.first_visit = (visit_r == '0);
  assign ctl.last_visit  = (visit_r == VW'(WORDS));
  assign ctl.tail_word   = (word_r == WW'(WORDS - 1));
  assign ctl.start_bit   = search_r[BIT_W-1:0];

  always_comb begin
    state_nxt     = state_r;
    search_nxt    = search_r;
    count_nxt     = count_r;
    word_nxt      = word_r;
    visit_nxt     = visit_r;
    rel_bit_nxt   = rel_bit_r;
    rel_slot_nxt  = rel_slot_r;
    res_grant_nxt = res_grant_r;
    res_slot_nxt  = res_slot_r;
    res_err_nxt   = res_err_r;
    out_vld_nxt   = out_vld_r && !out_tready;
    out_grant_nxt = out_grant_r;
    out_slot_nxt  = out_slot_r;
    out_err_nxt   = out_err_r;
    out_live_nxt  = out_live_r;
    rd_en         = 1'b0;
    rd_addr       = word_inc;
    wr_en         = 1'b0;
    wr_addr       = word_r;
    wr_data       = rd_data;
    count_wide    = CXW'(count_r);

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          rel_slot_nxt = in_tdata;
          rel_bit_nxt  = slot_wide[BIT_W-1:0];
          visit_nxt    = '0;
          if (in_tuser[0] == ACT_ALLOC) begin
            rd_en     = 1'b1;
            rd_addr   = start_word;
            word_nxt  = start_word;
            state_nxt = ST_SCAN;
          end else if (slot_in_pool) begin
            rd_en     = 1'b1;
            rd_addr   = WW'(slot_wide >> BIT_W);
            word_nxt  = WW'(slot_wide >> BIT_W);
            state_nxt = ST_REL;
          end else begin
            res_grant_nxt = 1'b0;
            res_slot_nxt  = in_tdata;
            res_err_nxt   = ERR_NOT_BUSY;
            state_nxt     = ST_DONE;
          end
        end
      end
      ST_SCAN: begin
        if (ffz_found) begin
          wr_en         = 1'b1;
          wr_data       = rd_data | (map_word_t'(1) << ffz_bit);
          count_nxt     = count_r + 1'b1;
          search_nxt    = (alloc_idx == IXW'(SLOTS - 1)) ? '0 : alloc_idx + 1'b1;
          res_grant_nxt = 1'b1;
          res_slot_nxt  = alloc_wide[7:0];
          res_err_nxt   = ERR_OK;
          state_nxt     = ST_DONE;
        end else if (ctl.last_visit) begin
          res_grant_nxt = 1'b0;
          res_slot_nxt  = '0;
          res_err_nxt   = ERR_POOL_FULL;
          state_nxt     = ST_DONE;
        end else begin
          // fetch the following row while this one is checked
          rd_en     = 1'b1;
          word_nxt  = word_inc;
          visit_nxt = visit_r + 1'b1;
        end
      end
      ST_REL: begin
        res_slot_nxt = rel_slot_r;
        if (rd_data[rel_bit_r]) begin
          wr_en         = 1'b1;
          wr_data       = rd_data & ~(map_word_t'(1) << rel_bit_r);
          count_nxt     = (count_r != '0) ? count_r - 1'b1 : count_r;
          res_grant_nxt = 1'b1;
          res_err_nxt   = ERR_OK;
        end else begin
          res_grant_nxt = 1'b0;
          res_err_nxt   = ERR_NOT_BUSY;
        end
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_vld_r || out_tready) begin
          out_vld_nxt   = 1'b1;
          out_grant_nxt = res_grant_r;
          out_slot_nxt  = res_slot_r;
          out_err_nxt   = res_err_r;
          out_live_nxt  = count_wide[8:0];
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      search_r  <= '0;
      count_r   <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      search_r  <= search_nxt;
      count_r   <= count_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    word_r      <= word_nxt;
    visit_r     <= visit_nxt;
    rel_bit_r   <= rel_bit_nxt;
    rel_slot_r  <= rel_slot_nxt;
    res_grant_r <= res_grant_nxt;
    res_slot_r  <= res_slot_nxt;
    res_err_r   <= res_err_nxt;
    out_grant_r <= out_grant_nxt;
    out_slot_r  <= out_slot_nxt;
    out_err_r   <= out_err_nxt;
    out_live_r  <= out_live_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {7'd0, out_live_r, out_slot_r};
  assign out_tuser  = {out_err_r, out_grant_r};

endmodule
`default_nettype wire

/* hw/rtl/nfsa_map.sv */
// Busy map storage: one 32-bit word per row, rows read as zero until written.
`default_nettype none
module nfsa_map #(
  parameter int WORDS = 8,
  parameter int WW    = 3
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                rd_en,
  input  wire logic [WW-1:0]       rd_addr,
  output nfsa_pkg::map_word_t      rd_data,
  input  wire logic                wr_en,
  input  wire logic [WW-1:0]       wr_addr,
  input  wire nfsa_pkg::map_word_t wr_data
);
  import nfsa_pkg::*;

  map_word_t        mem_r [WORDS];
  logic [WORDS-1:0] row_vld_r;
  map_word_t        rd_word_r;
  logic             rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_word_r <= mem_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
      rd_vld_r  <= 1'b0;
    end else begin
      if (wr_en) begin
        row_vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= row_vld_r[rd_addr];
      end
    end
  end

  // a row never written holds all-free slots
  assign rd_data = rd_vld_r ? rd_word_r : '0;

endmodule
`default_nettype wire

/* hw/rtl/nfsa_ffz.sv */
// Find-first-free unit: masks one busy-map word and finds its lowest zero bit.
`default_nettype none
module nfsa_ffz #(
  parameter int TAIL_BITS = 32
) (
  input  wire nfsa_pkg::map_word_t word,
  input  wire nfsa_pkg::scan_ctl_t ctl,
  output logic                     found,
  output nfsa_pkg::bit_sel_t       first_bit
);
  import nfsa_pkg::*;

  map_word_t blocked;

  always_comb begin
    for (int i = 0; i < WORD_W; i++) begin
      blocked[i] = word[i]
                 | (ctl.first_visit && (BIT_W'(i) < ctl.start_bit))
                 | (ctl.last_visit && (BIT_W'(i) >= ctl.start_bit))
                 | (ctl.tail_word && (i >= TAIL_BITS));
    end
  end

  always_comb begin
    found     = 1'b0;
    first_bit = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (!blocked[i]) begin
        found     = 1'b1;
        first_bit = BIT_W'(i);
      end
    end
  end

endmodule
`default_nettype wire
